[hw/rtl/ecgd_pkg.sv]
package ecgd_pkg;

  // default sizes of the stores
  localparam int MAX_NODES_DEF = 128;
  localparam int MAX_EDGES_DEF = 512;
  localparam int FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int AMT_W        = 48;
  localparam int RATE_W       = 24;
  localparam int FEE_W        = 32;
  localparam int NODE_FIELD_W = 7;
  localparam int CC_W         = 8;
  localparam int CMD_W        = 2;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_SEL_W  = 2;

  localparam logic [REG_SEL_W-1:0] REG_CURRENCY_COUNT  = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_SOURCE_CURRENCY = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_START_AMOUNT    = 2'd2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [NODE_FIELD_W-1:0] edge_from;
    logic [NODE_FIELD_W-1:0] edge_to;
    logic [RATE_W-1:0]       edge_rate;
    logic [FEE_W-1:0]        edge_fee;
  } in_t;

  typedef struct packed {
    logic gain_possible;
    logic edges_dropped;
  } out_t;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0] edge_from;
    logic [NODE_FIELD_W-1:0] edge_to;
    logic [RATE_W-1:0]       edge_rate;
    logic [FEE_W-1:0]        edge_fee;
  } edge_t;

endpackage

[hw/rtl/ecgd_conv.sv]
module ecgd_conv #(
  parameter int FRAC_BITS = ecgd_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ecgd_pkg::AMT_W-1:0]   amt,
  input  logic [ecgd_pkg::FEE_W-1:0]   fee,
  input  logic [ecgd_pkg::RATE_W-1:0]  rate,
  output logic                         done,
  output logic [ecgd_pkg::AMT_W-1:0]   result
);
  import ecgd_pkg::*;

  localparam int SHIFT  = RATE_W - FRAC_BITS;
  localparam int PROD_W = 2 * RATE_W;
  localparam int SUM_W  = PROD_W + SHIFT + 1;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_LO   = 4'b0010,
    C_HI   = 4'b0100,
    C_SUM  = 4'b1000
  } cstate_t;

  cstate_t             state_r, state_nxt;
  logic                done_r;
  logic [AMT_W-1:0]    d_r;
  logic [RATE_W-1:0]   rate_r;
  logic [PROD_W-1:0]   lo_r, hi_r;
  logic [AMT_W-1:0]    res_r;

  logic [AMT_W-1:0]    diff;
  logic [RATE_W-1:0]   mul_a;
  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    sum;

  // fee is taken off first, clamped at zero
  assign diff = (amt > AMT_W'(fee)) ? (amt - AMT_W'(fee)) : '0;

  // the one shared multiplier: low slice first, then high slice
  assign mul_a = (state_r == C_HI) ? d_r[AMT_W-1:RATE_W] : d_r[RATE_W-1:0];
  assign prod  = PROD_W'(mul_a) * PROD_W'(rate_r);

  assign sum = (SUM_W'(hi_r) << SHIFT) + SUM_W'(lo_r >> FRAC_BITS);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: if (start) state_nxt = C_LO;
      C_LO:   state_nxt = C_HI;
      C_HI:   state_nxt = C_SUM;
      C_SUM:  state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == C_SUM);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && start) begin
      d_r    <= diff;
      rate_r <= rate;
    end
    if (state_r == C_LO) lo_r <= prod;
    if (state_r == C_HI) hi_r <= prod;
    if (state_r == C_SUM) begin
      // saturate at full scale
      res_r <= (|sum[SUM_W-1:AMT_W]) ? {AMT_W{1'b1}} : sum[AMT_W-1:0];
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

[hw/rtl/exchange_cycle_gain_detector.sv]
// exchange cycle gain detector
// input channel (in_valid / in_stall / in_data) carries one command per transfer:
//   clear empties the edge table, append stores one edge, run starts detection.
//   clear and append give no result. an append to a full
//   table is dropped and sets the dropped flag until the next clear.
// a run gives one result on the output channel (out_valid / out_stall / out_data):
//   gain_possible and edges_dropped.
// a run first initialises the amounts, then makes up to currency_count-1
//   relaxation passes over the edges and one check pass, which ends at the
//   first improving edge; an edge with an out-of-range end is skipped without
//   a conversion. the result is then loaded. each edge reads both of its
//   amounts at once and uses the single 24x24 multiplier twice.
// in_stall stays high for the whole run; commands are taken only when idle.
// the result waits in an output register; while a result there is stalled,
//   the block holds in its final state until the register frees up.
// configuration uses the apb port: 0x00 currency_count, 0x08 source_currency,
//   0x10 start_amount. write only while idle. pready is always high.
// reset (synchronous, active low) empties the edge table, clears the dropped
//   flag and sets the registers to 1, 0 and 0.
module exchange_cycle_gain_detector #(
  parameter int MAX_NODES = ecgd_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = ecgd_pkg::MAX_EDGES_DEF,
  parameter int FRAC_BITS = ecgd_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ecgd_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ecgd_pkg::out_t                    out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ecgd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ecgd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ecgd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import ecgd_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int IDX_W  = (NODE_W > NODE_FIELD_W) ? NODE_W : NODE_FIELD_W;
  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INIT      = 7'b0000010,
    S_NEXT      = 7'b0000100,
    S_NODE_RD   = 7'b0001000,
    S_CONV_GO   = 7'b0010000,
    S_CONV_WAIT = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  // configuration
  logic [CC_W-1:0]         cc_r;
  logic [NODE_FIELD_W-1:0] src_r;
  logic [AMT_W-1:0]        start_r;
  logic                    cfg_wr;

  // control
  state_t              state_r, state_nxt;
  logic [ECNT_W-1:0]   edge_count_r, edge_count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [NODE_W-1:0]   sweep_r, sweep_nxt;
  logic [ECNT_W-1:0]   k_r, k_nxt;
  logic [CC_W-1:0]     round_r, round_nxt;
  logic                changed_r, changed_nxt;
  logic                check_r, check_nxt;
  logic                gain_r, gain_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r;

  // stores
  edge_t               edge_mem [MAX_EDGES];
  edge_t               edge_q_r;
  logic [AMT_W-1:0]    node_mem [MAX_NODES];
  logic [AMT_W-1:0]    amt_a_q_r, amt_b_q_r;

  logic                in_acc;
  logic                edge_wr;
  logic                node_wr;
  logic [NODE_W-1:0]   node_wr_addr;
  logic [AMT_W-1:0]    node_wr_data;
  logic [CC_W-1:0]     rounds;
  logic [IDX_W:0]      from_ext, to_ext, sweep_ext, src_ext;
  logic                ends_ok;
  logic [NODE_W-1:0]   a_addr, b_addr;
  logic                conv_start, conv_done;
  logic [AMT_W-1:0]    conv_res;
  logic                improve;
  logic                out_load;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r    <= CC_W'(1);
      src_r   <= '0;
      start_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        REG_CURRENCY_COUNT:  cc_r    <= pwdata[CC_W-1:0];
        REG_SOURCE_CURRENCY: src_r   <= pwdata[NODE_FIELD_W-1:0];
        REG_START_AMOUNT:    start_r <= pwdata[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_CURRENCY_COUNT:  prdata = CFG_DATA_W'(cc_r);
      REG_SOURCE_CURRENCY: prdata = CFG_DATA_W'(src_r);
      REG_START_AMOUNT:    prdata = CFG_DATA_W'(start_r);
      default:             prdata = '0;
    endcase
  end

  // ---------------- datapath helpers ----------------
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign rounds   = (cc_r == '0) ? '0 : (cc_r - CC_W'(1));

  assign from_ext  = (IDX_W+1)'(edge_q_r.edge_from);
  assign to_ext    = (IDX_W+1)'(edge_q_r.edge_to);
  assign sweep_ext = (IDX_W+1)'(sweep_r);
  assign src_ext   = (IDX_W+1)'(src_r);
  assign ends_ok   = (from_ext < (IDX_W+1)'(MAX_NODES)) &&
                     (to_ext < (IDX_W+1)'(MAX_NODES));
  assign a_addr    = from_ext[NODE_W-1:0];
  assign b_addr    = to_ext[NODE_W-1:0];

  assign conv_start = (state_r == S_CONV_GO);
  assign improve    = (amt_b_q_r < conv_res);

  ecgd_conv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .amt    (amt_a_q_r),
    .fee    (edge_q_r.edge_fee),
    .rate   (edge_q_r.edge_rate),
    .done   (conv_done),
    .result (conv_res)
  );

  // ---------------- edge table ----------------
  assign edge_wr = in_acc && (in_data.cmd == CMD_APPEND) &&
                   (edge_count_r != ECNT_W'(MAX_EDGES));

  always_ff @(posedge clk) begin
    if (edge_wr) begin
      edge_mem[edge_count_r[EIDX_W-1:0]] <= '{edge_from: in_data.edge_from,
                                              edge_to:   in_data.edge_to,
                                              edge_rate: in_data.edge_rate,
                                              edge_fee:  in_data.edge_fee};
    end
    edge_q_r <= edge_mem[k_r[EIDX_W-1:0]];
  end

  // ---------------- amounts ----------------
  // the init sweep zeroes every amount and loads the source
  assign node_wr = (state_r == S_INIT) ||
                   ((state_r == S_CONV_WAIT) && conv_done && improve && !check_r);
  assign node_wr_addr = (state_r == S_INIT) ? sweep_r : b_addr;
  assign node_wr_data = (state_r == S_INIT) ?
                        ((sweep_ext == src_ext) ? start_r : '0) : conv_res;

  always_ff @(posedge clk) begin
    if (node_wr) node_mem[node_wr_addr] <= node_wr_data;
    amt_a_q_r <= node_mem[a_addr];
    amt_b_q_r <= node_mem[b_addr];
  end

  // ---------------- sequencer ----------------
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    edge_count_nxt = edge_count_r;
    ovf_nxt        = ovf_r;
    sweep_nxt      = sweep_r;
    k_nxt          = k_r;
    round_nxt      = round_r;
    changed_nxt    = changed_r;
    check_nxt      = check_r;
    gain_nxt       = gain_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.cmd)
            CMD_CLEAR: begin
              edge_count_nxt = '0;
              ovf_nxt        = 1'b0;
            end
            CMD_APPEND: begin
              if (edge_count_r != ECNT_W'(MAX_EDGES)) begin
                edge_count_nxt = edge_count_r + ECNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_RUN: begin
              state_nxt   = S_INIT;
              sweep_nxt   = '0;
              k_nxt       = '0;
              round_nxt   = '0;
              changed_nxt = 1'b0;
              check_nxt   = (rounds == '0);
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        sweep_nxt = sweep_r + NODE_W'(1);
        if (sweep_r == NODE_W'(MAX_NODES - 1)) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (k_r == edge_count_r) begin
          k_nxt       = '0;
          changed_nxt = 1'b0;
          if (check_r) begin
            gain_nxt  = 1'b0;
            state_nxt = S_DONE;
          end else if (!changed_r || (round_r + CC_W'(1) == rounds)) begin
            check_nxt = 1'b1;
          end else begin
            round_nxt = round_r + CC_W'(1);
          end
        end else begin
          state_nxt = S_NODE_RD;
        end
      end
      S_NODE_RD: begin
        if (ends_ok) begin
          state_nxt = S_CONV_GO;
        end else begin
          k_nxt     = k_r + ECNT_W'(1);
          state_nxt = S_NEXT;
        end
      end
      S_CONV_GO: state_nxt = S_CONV_WAIT;
      S_CONV_WAIT: begin
        if (conv_done) begin
          if (improve && check_r) begin
            gain_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            if (improve) changed_nxt = 1'b1;
            k_nxt     = k_r + ECNT_W'(1);
            state_nxt = S_NEXT;
          end
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      edge_count_r <= '0;
      ovf_r        <= 1'b0;
      sweep_r      <= '0;
      k_r          <= '0;
      round_r      <= '0;
      changed_r    <= 1'b0;
      check_r      <= 1'b0;
      gain_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      edge_count_r <= edge_count_nxt;
      ovf_r        <= ovf_nxt;
      sweep_r      <= sweep_nxt;
      k_r          <= k_nxt;
      round_r      <= round_nxt;
      changed_r    <= changed_nxt;
      check_r      <= check_nxt;
      gain_r       <= gain_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.gain_possible <= gain_r;
      out_data_r.edges_dropped <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks ----------------
  a_dropped_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (edge_count_r == ECNT_W'(MAX_EDGES)))
    else $error("dropped flag set while edge table not full");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    edge_count_r <= ECNT_W'(MAX_EDGES))
    else $error("edge count beyond table depth");

  a_conv_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> (state_r == S_CONV_WAIT))
    else $error("conversion finished outside the wait state");

  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised without a finished run");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NODE_RD) |-> (k_r < edge_count_r))
    else $error("edge index read past the edge count");

endmodule
